/* design/gdad_pkg.sv */
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DAYS_W  = 16;
  localparam int IN_W    = 40;  // 39 payload bits padded to whole bytes
  localparam int OUT_W   = 32;  // 25 payload bits padded to whole bytes

  localparam logic [YEAR_W-1:0] MIN_YEAR_DEF = YEAR_W'(1601);
  localparam logic [YEAR_W-1:0] YEAR_MAX     = {YEAR_W{1'b1}};

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
  localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;

  // year / 25 by reciprocal: floor(y * 20972 / 2^19) is exact for 14-bit y
  localparam int RECIP_SH = 19;
  localparam int RECIP_W  = 15;
  localparam int PROD_W   = YEAR_W + RECIP_W;
  localparam int QUOT_W   = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP_25 = 15'd20972;
  localparam logic [4:0]         MOD25_LAST = 5'd24;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic mul;       // register year * reciprocal
    logic rem;       // register year mod 25
    logic chk;       // register start date validity
    logic step;      // advance by one month or finish
    logic out_load;  // copy result into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic chk_ok;     // start date is valid
    logic step_last;  // current step finishes the request
  } stat_t;

  // Leap year from the low year bits and whether year mod 25 is zero
  function automatic logic leap_year(input logic [3:0] y_lo, input logic mod25_zero);
    leap_year = (y_lo[1:0] == 2'd0) && (!mod25_zero || (y_lo == 4'd0));
  endfunction

  // Month length; meaningless month codes read as 31
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == MONTH_FEB && leap) begin
      days_in_month = FEB_LEAP;
    end else if (m < MONTH_JAN || m > MONTH_DEC) begin
      days_in_month = DAY_LAST;
    end else begin
      days_in_month = MONTH_LEN[idx];
    end
  endfunction

endpackage

/* design/gdad_ctrl.sv */
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: accepts a request, walks the datapath through its setup
// cycles and month steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  gdad_pkg::stat_t stat,
  output gdad_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_REM  = 6'b000100,
    S_CHK  = 6'b001000,
    S_STEP = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.chk_ok ? S_STEP : S_DONE;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: drop on take, raise on load
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/gdad_dpath.sv */
// ----------------------------------------------------------------------------
// gdad_dpath
// Date registers, year-mod-25 setup, validity check, one-month step unit
// and the output register.
// ----------------------------------------------------------------------------
module gdad_dpath #(
  parameter logic [gdad_pkg::YEAR_W-1:0] MIN_YEAR = gdad_pkg::MIN_YEAR_DEF
) (
  input  logic                        clk,
  input  gdad_pkg::cmd_t              cmd,
  input  logic [gdad_pkg::IN_W-1:0]   in_tdata,
  output logic [gdad_pkg::OUT_W-1:0]  out_tdata,
  output gdad_pkg::stat_t             stat
);

  localparam int DW = gdad_pkg::DAY_W;
  localparam int MW = gdad_pkg::MONTH_W;
  localparam int YW = gdad_pkg::YEAR_W;
  localparam int LW = gdad_pkg::DAYS_W;

  logic [DW-1:0]               d_r;
  logic [MW-1:0]               m_r;
  logic [YW-1:0]               y_r;
  logic [LW-1:0]               left_r;
  logic [4:0]                  y25_r;
  logic [gdad_pkg::PROD_W-1:0] prod_r;
  logic                        valid_r;
  logic                        ovf_r;
  logic [gdad_pkg::OUT_W-1:0]  out_r;

  logic [gdad_pkg::QUOT_W-1:0] quot;
  logic [YW:0]                 qx25;
  logic [YW:0]                 rem_full;
  logic                        leap;
  logic [DW-1:0]               dim;
  logic [DW-1:0]               room;
  logic                        fits;
  logic                        at_end;

  // Year mod 25 from the registered reciprocal product
  assign quot     = prod_r[gdad_pkg::PROD_W-1:gdad_pkg::RECIP_SH];
  assign qx25     = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + (YW+1)'(quot);
  assign rem_full = {1'b0, y_r} - qx25;

  // Month length and room left in the current month
  assign leap   = gdad_pkg::leap_year(y_r[3:0], y25_r == 5'd0);
  assign dim    = gdad_pkg::days_in_month(m_r, leap);
  assign room   = dim - d_r;
  assign fits   = left_r <= LW'(room);
  assign at_end = (m_r == gdad_pkg::MONTH_DEC) && (y_r == gdad_pkg::YEAR_MAX);

  assign stat.chk_ok    = (y_r >= MIN_YEAR) && (m_r >= gdad_pkg::MONTH_JAN) &&
                          (m_r <= gdad_pkg::MONTH_DEC) && (d_r != '0) && (d_r <= dim);
  assign stat.step_last = fits || at_end;

  // Date state and setup registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r     <= in_tdata[4:0];
      m_r     <= in_tdata[8:5];
      y_r     <= in_tdata[22:9];
      left_r  <= in_tdata[38:23];
      valid_r <= 1'b0;
      ovf_r   <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r <= gdad_pkg::PROD_W'(y_r) * gdad_pkg::PROD_W'(gdad_pkg::RECIP_25);
    end
    if (cmd.rem) begin
      y25_r <= rem_full[4:0];
    end
    if (cmd.chk) begin
      valid_r <= stat.chk_ok;
    end
    // Advance: finish inside this month, stop at the last date, or roll over
    if (cmd.step) begin
      if (fits) begin
        d_r    <= d_r + left_r[DW-1:0];
        left_r <= '0;
      end else if (at_end) begin
        d_r   <= gdad_pkg::DAY_LAST;
        ovf_r <= 1'b1;
      end else begin
        left_r <= left_r - LW'(room) - LW'(1);
        d_r    <= DW'(1);
        if (m_r == gdad_pkg::MONTH_DEC) begin
          m_r   <= gdad_pkg::MONTH_JAN;
          y_r   <= y_r + YW'(1);
          y25_r <= (y25_r == gdad_pkg::MOD25_LAST) ? 5'd0 : y25_r + 5'd1;
        end else begin
          m_r <= m_r + MW'(1);
        end
      end
    end
    if (cmd.out_load) begin
      out_r <= {7'd0, ovf_r, valid_r, y_r, m_r, d_r};
    end
  end

  assign out_tdata = out_r;

endmodule

/* design/gregorian_date_add_days_top.sv */
// Sequence: capture the request, register year * reciprocal, register year mod 25,
//   check the start date, step month by month until done, then load the output register;
//   an invalid start date skips the month steps. One request is in work at a time.
//   A new request is taken while the previous result waits at the output.
// Reset: synchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top
// Adds a day count to a Gregorian date, with validity and year saturation.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top #(
  parameter logic [gdad_pkg::YEAR_W-1:0] MIN_YEAR = gdad_pkg::MIN_YEAR_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year, [38:23] days_to_add
  input  logic [gdad_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [4:0] result_day, [8:5] result_month, [22:9] result_year,
  // [23] start_valid, [24] year_overflow
  output logic [gdad_pkg::OUT_W-1:0] out_tdata
);

  gdad_pkg::cmd_t  cmd;
  gdad_pkg::stat_t stat;

  // Sequencer
  gdad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Date datapath
  gdad_dpath #(
    .MIN_YEAR (MIN_YEAR)
  ) u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .stat      (stat)
  );

endmodule

/* design/gdad_chk.sv */
// ----------------------------------------------------------------------------
// gdad_chk
// Port-level checks for the date adder, bound to the top level.
// ----------------------------------------------------------------------------
module gdad_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [gdad_pkg::OUT_W-1:0] out_tdata
);

  // Output request holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request changed while stalled");

  // Valid start dates give an in-range day and month
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23] |->
      out_tdata[4:0] != 5'd0 && out_tdata[8:5] >= gdad_pkg::MONTH_JAN &&
      out_tdata[8:5] <= gdad_pkg::MONTH_DEC)
    else $error("result date out of range");

  // Overflow only on valid dates, pinned at the last date
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |->
      out_tdata[23] && out_tdata[4:0] == gdad_pkg::DAY_LAST &&
      out_tdata[8:5] == gdad_pkg::MONTH_DEC && out_tdata[22:9] == gdad_pkg::YEAR_MAX)
    else $error("overflow without saturated date");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind gregorian_date_add_days_top gdad_chk u_gdad_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
